// File: hw/rtl/dipd_pkg.sv
// Package for the icon DIB pixel decoder: sizes, codes, state and struct types.
// Used by every file of the block but dipd_ram; depends on nothing.
package dipd_pkg;

  localparam int unsigned MAX_DIM     = 256;
  localparam int unsigned STORE_BYTES = 262144;

  localparam int unsigned ST_AW      = $clog2(STORE_BYTES);
  localparam int unsigned END_W      = $clog2(STORE_BYTES + 1);
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned BPP_W      = 6;
  localparam int unsigned LEN_W      = 19;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ADDR_W     = 18;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 19;
  localparam int unsigned RB_W       = $clog2(MAX_DIM * 4 + 1);
  localparam int unsigned MRB_W      = $clog2(((MAX_DIM + 31) / 32) * 4 + 1);
  localparam int unsigned PROD_W     = RB_W + DIM_W;
  localparam int unsigned CALC_W     = (PROD_W + 2 > END_W + 1) ? PROD_W + 2 : END_W + 1;
  localparam int unsigned PAL_W      = 11;

  localparam logic [BPP_W-1:0] BPP_1  = BPP_W'(1);
  localparam logic [BPP_W-1:0] BPP_4  = BPP_W'(4);
  localparam logic [BPP_W-1:0] BPP_8  = BPP_W'(8);
  localparam logic [BPP_W-1:0] BPP_24 = BPP_W'(24);
  localparam logic [BPP_W-1:0] BPP_32 = BPP_W'(32);

  localparam logic [PAL_W-1:0] PAL_BYTES_1 = PAL_W'(8);
  localparam logic [PAL_W-1:0] PAL_BYTES_4 = PAL_W'(64);
  localparam logic [PAL_W-1:0] PAL_BYTES_8 = PAL_W'(1024);

  typedef enum logic [1:0] {
    ST_OK,
    ST_DEPTH,
    ST_PALETTE,
    ST_OUTSIDE
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_DEPTH,
    REG_LENGTH
  } cfg_reg_e;

  typedef enum logic {
    KIND_WRITE,
    KIND_READ
  } kind_e;

  typedef enum logic [2:0] {
    DEPTH_NONE,
    DEPTH_1,
    DEPTH_4,
    DEPTH_8,
    DEPTH_24,
    DEPTH_32
  } depth_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_ADDR,
    S_IDX,
    S_IDXW,
    S_RB,
    S_RG,
    S_RR,
    S_RA,
    S_CAP,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [BPP_W-1:0] depth;
    logic [LEN_W-1:0] length;
  } cfg_t;

  typedef struct packed {
    status_e          status;
    depth_e           depth;
    logic             pal;
    logic [PAL_W-1:0] off;
    logic [RB_W-1:0]  rb;
    logic [MRB_W-1:0] mrb;
    logic [DIM_W-1:0] y;
    logic [DIM_W-1:0] h;
    logic [END_W-1:0] pay_end;
  } geom_t;

endpackage

// File: hw/rtl/dipd_if.sv
// Channel interfaces of the icon DIB pixel decoder: request, result, config write.
// Depends on dipd_pkg.
interface dipd_req_if import dipd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [ADDR_W-1:0]  byte_address;
  logic [BYTE_W-1:0]  byte_value;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row_from_top;

  modport source (
    output valid, kind, byte_address, byte_value, column, row_from_top,
    input  ready
  );
  modport sink (
    input  valid, kind, byte_address, byte_value, column, row_from_top,
    output ready
  );
endinterface

interface dipd_res_if import dipd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  logic [BYTE_W-1:0] alpha;
  logic [1:0]        status;

  modport source (
    output valid, red, green, blue, alpha, status,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, alpha, status,
    output ready
  );
endinterface

interface dipd_cfg_if import dipd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: hw/rtl/dipd_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Self-contained; no package needed.
module dipd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/dipd_geom.sv
// Image geometry and request status from the configuration and pixel coordinates.
// Depends on dipd_pkg.
module dipd_geom import dipd_pkg::*; (
  input  cfg_t               cfg_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [COORD_W-1:0] row_i,
  output geom_t              geom_o
);

  depth_e            depth;
  logic              pal;
  logic              bad_dim;
  logic [PAL_W-1:0]  off;
  logic [CALC_W-1:0] w_ext;
  logic [CALC_W-1:0] row_raw;
  logic [END_W-1:0]  pay_end;

  always_comb begin
    unique case (cfg_i.depth)
      BPP_1:   depth = DEPTH_1;
      BPP_4:   depth = DEPTH_4;
      BPP_8:   depth = DEPTH_8;
      BPP_24:  depth = DEPTH_24;
      BPP_32:  depth = DEPTH_32;
      default: depth = DEPTH_NONE;
    endcase
  end

  assign pal   = (depth == DEPTH_1) || (depth == DEPTH_4) || (depth == DEPTH_8);
  assign w_ext = CALC_W'(cfg_i.width);

  always_comb begin
    case (depth)
      DEPTH_8: off = PAL_BYTES_8;
      DEPTH_4: off = PAL_BYTES_4;
      DEPTH_1: off = PAL_BYTES_1;
      default: off = '0;
    endcase
  end

  always_comb begin
    case (depth)
      DEPTH_32: row_raw = w_ext << 2;
      DEPTH_24: row_raw = (((w_ext + (w_ext << 1)) + CALC_W'(3)) >> 2) << 2;
      DEPTH_8:  row_raw = (((w_ext << 3) + CALC_W'(31)) >> 5) << 2;
      DEPTH_4:  row_raw = (((w_ext << 2) + CALC_W'(31)) >> 5) << 2;
      DEPTH_1:  row_raw = ((w_ext + CALC_W'(31)) >> 5) << 2;
      default:  row_raw = '0;
    endcase
  end

  assign pay_end = (32'(cfg_i.length) < 32'(STORE_BYTES)) ? END_W'(cfg_i.length)
                                                          : END_W'(STORE_BYTES);

  assign bad_dim = (cfg_i.width == '0) || (32'(cfg_i.width) > 32'(MAX_DIM)) ||
                   (cfg_i.height == '0) || (32'(cfg_i.height) > 32'(MAX_DIM)) ||
                   (DIM_W'(col_i) >= cfg_i.width) || (DIM_W'(row_i) >= cfg_i.height);

  always_comb begin
    if (depth == DEPTH_NONE) begin
      geom_o.status = ST_DEPTH;
    end else if (pal && (CALC_W'(off) >= CALC_W'(pay_end))) begin
      geom_o.status = ST_PALETTE;
    end else if (bad_dim) begin
      geom_o.status = ST_OUTSIDE;
    end else begin
      geom_o.status = ST_OK;
    end
    geom_o.depth   = depth;
    geom_o.pal     = pal;
    geom_o.off     = off;
    geom_o.rb      = RB_W'(row_raw);
    geom_o.mrb     = MRB_W'(((w_ext + CALC_W'(31)) >> 5) << 2);
    geom_o.y       = cfg_i.height - DIM_W'(1) - DIM_W'(row_i);
    geom_o.h       = cfg_i.height;
    geom_o.pay_end = pay_end;
  end

endmodule

// File: hw/rtl/dib_icon_pixel_decoder_unit.sv
// Icon DIB pixel decoder top level: config registers, sequencer, payload byte RAM.
// Payload writes are accepted back to back while no pixel read is in progress.
// A pixel read runs check, multiply, address, index fetch (palette depths only), one RAM
// read per colour byte and mask, capture and finish; an error status or short row skips to finish.
// Requests are taken one at a time; the result register frees the next request early.
// Reset clears config to width 1, height 1, depth 32, length 0; RAM contents stay undefined.
module dib_icon_pixel_decoder_unit import dipd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dipd_req_if.sink  req_i,
  dipd_res_if.source res_o,
  dipd_cfg_if.sink  cfg_i
);

  state_e state_q, state_d;
  cfg_t   cfg_q, cfg_d;
  geom_t  geom_c, geom_q;

  logic [COORD_W-1:0] x_q, yt_q;
  logic [PROD_W-1:0]  base_q, csize_q, moff_q;
  logic [ST_AW-1:0]   cb_q, maddr_q;
  logic               mvalid_q, zero_q;
  logic [BYTE_W-1:0]  r_q, g_q, b_q, a_q;

  logic               res_valid_q, res_valid_d;
  logic [BYTE_W-1:0]  red_q, green_q, blue_q, alpha_q;
  status_e            status_q;

  logic               ram_we;
  logic [ST_AW-1:0]   ram_addr;
  logic [BYTE_W-1:0]  ram_rdata;
  logic               in_range;
  logic               res_load;

  logic [CALC_W-1:0]  row_base, row_end, pix_off, pix_addr, mask_addr;
  logic               short_c, mvalid_c;
  logic [BYTE_W-1:0]  idx_c, alpha_c;
  logic [9:0]         pe_c;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_WIDTH:  cfg_d.width  = DIM_W'(cfg_i.data);
        REG_HEIGHT: cfg_d.height = DIM_W'(cfg_i.data);
        REG_DEPTH:  cfg_d.depth  = BPP_W'(cfg_i.data);
        REG_LENGTH: cfg_d.length = LEN_W'(cfg_i.data);
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= DIM_W'(1);
      cfg_q.height <= DIM_W'(1);
      cfg_q.depth  <= BPP_32;
      cfg_q.length <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dipd_geom u_geom (
    .cfg_i  (cfg_q),
    .col_i  (x_q),
    .row_i  (yt_q),
    .geom_o (geom_c)
  );

  dipd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (req_i.byte_value),
    .rdata_o (ram_rdata)
  );

  // address arithmetic
  assign row_base = CALC_W'(geom_q.off) + CALC_W'(base_q);
  assign row_end  = row_base + CALC_W'(geom_q.rb);
  assign short_c  = row_end > CALC_W'(geom_q.pay_end);

  always_comb begin
    case (geom_q.depth)
      DEPTH_32: pix_off = CALC_W'(x_q) << 2;
      DEPTH_24: pix_off = CALC_W'(x_q) + (CALC_W'(x_q) << 1);
      DEPTH_8:  pix_off = CALC_W'(x_q);
      DEPTH_4:  pix_off = CALC_W'(x_q) >> 1;
      DEPTH_1:  pix_off = CALC_W'(x_q) >> 3;
      default:  pix_off = '0;
    endcase
  end

  assign pix_addr  = row_base + pix_off;
  assign mask_addr = CALC_W'(geom_q.off) + CALC_W'(csize_q) + CALC_W'(moff_q) +
                     (CALC_W'(x_q) >> 3);
  assign mvalid_c  = mask_addr < CALC_W'(geom_q.pay_end);

  always_comb begin
    case (geom_q.depth)
      DEPTH_8: idx_c = ram_rdata;
      DEPTH_4: idx_c = x_q[0] ? {4'b0000, ram_rdata[3:0]} : {4'b0000, ram_rdata[7:4]};
      DEPTH_1: idx_c = {7'b0000000, ram_rdata[~x_q[2:0]]};
      default: idx_c = '0;
    endcase
  end

  assign pe_c = {idx_c, 2'b00};

  always_comb begin
    if (geom_q.depth == DEPTH_32) begin
      alpha_c = ram_rdata;
    end else if (mvalid_q && ram_rdata[~x_q[2:0]]) begin
      alpha_c = '0;
    end else begin
      alpha_c = 8'hFF;
    end
  end

  assign in_range = 32'(req_i.byte_address) < 32'(STORE_BYTES);

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid && (req_i.kind == KIND_READ)) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: state_d = (geom_c.status != ST_OK) ? S_FIN : S_MUL;
      S_MUL:   state_d = S_ADDR;
      S_ADDR: begin
        if (short_c) begin
          state_d = S_FIN;
        end else if (geom_q.pal) begin
          state_d = S_IDX;
        end else begin
          state_d = S_RB;
        end
      end
      S_IDX:  state_d = S_IDXW;
      S_IDXW: state_d = S_RB;
      S_RB:   state_d = S_RG;
      S_RG:   state_d = S_RR;
      S_RR:   state_d = S_RA;
      S_RA:   state_d = S_CAP;
      S_CAP:  state_d = S_FIN;
      S_FIN: begin
        if (!res_valid_q || res_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    req_i.ready = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = cb_q;
    res_load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        ram_addr    = ST_AW'(req_i.byte_address);
        ram_we      = req_i.valid && (req_i.kind == KIND_WRITE) && in_range;
      end
      S_RG: ram_addr = cb_q + ST_AW'(1);
      S_RR: ram_addr = cb_q + ST_AW'(2);
      S_RA: ram_addr = (geom_q.depth == DEPTH_32) ? cb_q + ST_AW'(3) : maddr_q;
      S_FIN: res_load = !res_valid_q || res_o.ready;
      default: ram_addr = cb_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        x_q  <= req_i.column;
        yt_q <= req_i.row_from_top;
      end
      S_CHECK: begin
        geom_q <= geom_c;
        zero_q <= geom_c.status != ST_OK;
      end
      S_MUL: begin
        base_q  <= PROD_W'(geom_q.y) * PROD_W'(geom_q.rb);
        csize_q <= PROD_W'(geom_q.rb) * PROD_W'(geom_q.h);
        moff_q  <= PROD_W'(geom_q.y) * PROD_W'(geom_q.mrb);
      end
      S_ADDR: begin
        cb_q     <= ST_AW'(pix_addr);
        maddr_q  <= ST_AW'(mask_addr);
        mvalid_q <= mvalid_c;
        zero_q   <= short_c;
      end
      S_IDXW: cb_q <= ST_AW'(pe_c);
      S_RG:   b_q  <= ram_rdata;
      S_RR:   g_q  <= ram_rdata;
      S_RA:   r_q  <= ram_rdata;
      S_CAP:  a_q  <= alpha_c;
      default: ;
    endcase
  end

  // result register
  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      red_q    <= zero_q ? '0 : r_q;
      green_q  <= zero_q ? '0 : g_q;
      blue_q   <= zero_q ? '0 : b_q;
      alpha_q  <= zero_q ? '0 : a_q;
      status_q <= geom_q.status;
    end
  end

  assign res_o.valid  = res_valid_q;
  assign res_o.red    = red_q;
  assign res_o.green  = green_q;
  assign res_o.blue   = blue_q;
  assign res_o.alpha  = alpha_q;
  assign res_o.status = status_q;

endmodule

// File: hw/rtl/dipd_checker.sv
// Port-level assertions for the icon DIB pixel decoder, bound to the top level.
// Depends on dipd_pkg and dib_icon_pixel_decoder_unit.
module dipd_checker import dipd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              req_kind_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [BYTE_W-1:0] res_red_i,
  input logic [BYTE_W-1:0] res_green_i,
  input logic [BYTE_W-1:0] res_blue_i,
  input logic [BYTE_W-1:0] res_alpha_i,
  input logic [1:0]        res_status_i
);

  logic rd_acc, wr_acc;

  assign rd_acc = req_valid_i && req_ready_i && (req_kind_i == KIND_READ);
  assign wr_acc = req_valid_i && req_ready_i && (req_kind_i == KIND_WRITE);

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_status_i != ST_OK) |->
      (res_red_i == '0) && (res_green_i == '0) && (res_blue_i == '0) && (res_alpha_i == '0))
    else $error("error status with nonzero color");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_status_i))
    else $error("stalled result dropped or changed");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc |=> !req_ready_i)
    else $error("request taken while a read is in flight");

  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_acc |=> req_ready_i)
    else $error("byte write stalled the request channel");

endmodule

bind dib_icon_pixel_decoder_unit dipd_checker u_dipd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_kind_i   (req_i.kind),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_red_i    (res_o.red),
  .res_green_i  (res_o.green),
  .res_blue_i   (res_o.blue),
  .res_alpha_i  (res_o.alpha),
  .res_status_i (res_o.status)
);

// File: verif/dib_icon_pixel_decoder_unit_test.sv
// Self-checking bench for dib_icon_pixel_decoder_unit: payload loads, pixel reads, geometry setup.
// Pixel reads are predicted from a shadow payload store and the live register values.
// Depends on dipd_pkg and the channel interfaces in dipd_if.sv.
module dib_icon_pixel_decoder_unit_test;
  import dipd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_e              kind;
    logic [ADDR_W-1:0]  byte_address;
    logic [BYTE_W-1:0]  byte_value;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row_from_top;
  } dib_op_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    status_e           status;
  } rgba_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dipd_req_if req_bus ();
  dipd_res_if res_bus ();
  dipd_cfg_if cfg_bus ();

  dib_icon_pixel_decoder_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  logic [BYTE_W-1:0] payload_shadow [STORE_BYTES];
  logic [BYTE_W-1:0] payload_plan [STORE_BYTES];
  bit                payload_loaded [STORE_BYTES];
  int unsigned       missing_bytes [$];

  dib_op_t     pending_ops [$];
  rgba_t       expected_pixels [$];
  dib_op_t     in_flight;
  cfg_t        live_cfg;
  cfg_t        plan_cfg;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_cycles;
  int unsigned mismatches;
  bit          hold_request;
  bit          hold_taken;
  bit          calm;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned next_gap();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [BYTE_W-1:0] fetch_byte(int unsigned at, bit from_plan);
    if (!from_plan) return payload_shadow[ST_AW'(at)];
    if (!payload_loaded[ST_AW'(at)]) missing_bytes = {missing_bytes, at};
    return payload_plan[ST_AW'(at)];
  endfunction

  function automatic logic [BYTE_W-1:0] mask_alpha(input int unsigned mask_base, y, col, w, stop,
                                                   input bit from_plan);
    int unsigned at;
    logic [BYTE_W-1:0] m;
    at = mask_base + y * (((w + 31) / 32) * 4) + (col >> 3);
    if (at >= stop) return 8'hFF;
    m = fetch_byte(at, from_plan);
    return m[7 - (col & 7)] ? 8'h00 : 8'hFF;
  endfunction

  function automatic rgba_t decode_pixel(input cfg_t c, input int unsigned col, row_top,
                                         input bit from_plan);
    rgba_t px;
    int unsigned w, h, bpp, stop, bits, y, rb, base, at, idx, v;
    bit pal;
    px = '0;
    w = c.width;
    h = c.height;
    bpp = c.depth;
    stop = (c.length < STORE_BYTES) ? c.length : STORE_BYTES;
    pal = (c.depth == BPP_1) || (c.depth == BPP_4) || (c.depth == BPP_8);
    bits = 32'd4 << bpp;
    if (!pal && c.depth != BPP_24 && c.depth != BPP_32) begin
      px.status = ST_DEPTH;
    end else if (pal && bits >= stop) begin
      px.status = ST_PALETTE;
    end else if (w == 0 || w > MAX_DIM || h == 0 || h > MAX_DIM || col >= w || row_top >= h) begin
      px.status = ST_OUTSIDE;
    end else begin
      y = h - 1 - row_top;
      if (c.depth == BPP_32) begin
        rb = w * 4;
        base = y * rb;
        if (base + rb <= stop) begin
          at = base + col * 4;
          px.red   = fetch_byte(at + 2, from_plan);
          px.green = fetch_byte(at + 1, from_plan);
          px.blue  = fetch_byte(at, from_plan);
          px.alpha = fetch_byte(at + 3, from_plan);
        end
      end else if (c.depth == BPP_24) begin
        rb = ((w * 3 + 3) / 4) * 4;
        base = y * rb;
        if (base + rb <= stop) begin
          at = base + col * 3;
          px.red   = fetch_byte(at + 2, from_plan);
          px.green = fetch_byte(at + 1, from_plan);
          px.blue  = fetch_byte(at, from_plan);
          px.alpha = mask_alpha(rb * h, y, col, w, stop, from_plan);
        end
      end else begin
        rb = ((w * bpp + 31) / 32) * 4;
        base = bits + y * rb;
        if (base + rb <= stop) begin
          // pixels are packed from the most significant end of each byte
          v = fetch_byte(base + ((col * bpp) >> 3), from_plan);
          idx = (v >> (8 - bpp - ((col * bpp) & 7))) & ((1 << bpp) - 1);
          at = idx * 4;
          px.red   = fetch_byte(at + 2, from_plan);
          px.green = fetch_byte(at + 1, from_plan);
          px.blue  = fetch_byte(at, from_plan);
          px.alpha = mask_alpha(bits + rb * h, y, col, w, stop, from_plan);
        end
      end
    end
    return px;
  endfunction

  task automatic flag_mismatch(string what, rgba_t want, rgba_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected r=%02h g=%02h b=%02h a=%02h st=%0d,",
               $time, what, want.red, want.green, want.blue, want.alpha, want.status,
               " got r=%02h g=%02h b=%02h a=%02h st=%0d",
               got.red, got.green, got.blue, got.alpha, got.status);
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      send_gap <= 0;
    end else begin : drive
      int unsigned gap;
      logic busy;
      gap = send_gap;
      busy = req_bus.valid;
      if (req_bus.valid && req_bus.ready) begin
        if (in_flight.kind == KIND_WRITE) begin
          payload_shadow[in_flight.byte_address] = in_flight.byte_value;
        end else begin
          expected_pixels = {expected_pixels,
                             decode_pixel(live_cfg, in_flight.column,
                                          in_flight.row_from_top, 1'b0)};
        end
        busy = 1'b0;
        gap = next_gap();
      end else if (!busy && gap != 0) begin
        gap--;
      end
      if (!busy && gap == 0 && pending_ops.size() != 0) begin
        in_flight = pending_ops.pop_front();
        req_bus.kind <= in_flight.kind;
        req_bus.byte_address <= in_flight.byte_address;
        req_bus.byte_value <= in_flight.byte_value;
        req_bus.column <= in_flight.column;
        req_bus.row_from_top <= in_flight.row_from_top;
        busy = 1'b1;
      end
      req_bus.valid <= busy;
      send_gap <= gap;
    end
  end

  // long result hold-off, once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cycles <= 0;
      hold_taken <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_cycles <= 300;
      hold_taken <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      recv_gap <= 0;
    end else begin : collect
      int unsigned gap;
      rgba_t got;
      rgba_t want;
      gap = recv_gap;
      if (res_bus.valid && res_bus.ready) begin
        got = '{red: res_bus.red, green: res_bus.green, blue: res_bus.blue,
                alpha: res_bus.alpha, status: status_e'(res_bus.status)};
        if (expected_pixels.size() == 0) begin
          flag_mismatch("result with no read pending", '0, got);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) flag_mismatch("pixel mismatch", want, got);
        end
        gap = next_gap();
      end else if (gap != 0) begin
        gap--;
      end
      res_bus.ready <= (gap == 0) && (hold_cycles == 0);
      recv_gap <= gap;
    end
  end

  // register shadow
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_cfg <= '{width: 9'd1, height: 9'd1, depth: BPP_32, length: '0};
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      case (cfg_reg_e'(cfg_bus.index))
        REG_WIDTH:  live_cfg.width <= cfg_bus.data[DIM_W-1:0];
        REG_HEIGHT: live_cfg.height <= cfg_bus.data[DIM_W-1:0];
        REG_DEPTH:  live_cfg.depth <= cfg_bus.data[BPP_W-1:0];
        REG_LENGTH: live_cfg.length <= cfg_bus.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  task automatic settle();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || req_bus.valid || expected_pixels.size() != 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk_i);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_geometry(cfg_t c);
    settle();
    write_reg(REG_WIDTH, CFG_DATA_W'(c.width));
    write_reg(REG_HEIGHT, CFG_DATA_W'(c.height));
    write_reg(REG_DEPTH, CFG_DATA_W'(c.depth));
    write_reg(REG_LENGTH, CFG_DATA_W'(c.length));
    plan_cfg = c;
    @(negedge clk_i);
  endtask

  task automatic queue_write(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] val);
    dib_op_t op;
    payload_plan[addr] = val;
    payload_loaded[addr] = 1'b1;
    op = '{kind: KIND_WRITE, byte_address: addr, byte_value: val,
           column: COORD_W'($urandom_range(0, 255)),
           row_from_top: COORD_W'($urandom_range(0, 255))};
    pending_ops = {pending_ops, op};
  endtask

  // load every byte the read will touch before issuing it
  task automatic queue_read(logic [COORD_W-1:0] x, logic [COORD_W-1:0] yt);
    dib_op_t op;
    do begin
      missing_bytes.delete();
      void'(decode_pixel(plan_cfg, x, yt, 1'b1));
      foreach (missing_bytes[i]) begin
        queue_write(ADDR_W'(missing_bytes[i]), BYTE_W'($urandom_range(0, 255)));
      end
    end while (missing_bytes.size() != 0);
    op = '{kind: KIND_READ, byte_address: ADDR_W'($urandom_range(0, 262143)),
           byte_value: BYTE_W'($urandom_range(0, 255)), column: x, row_from_top: yt};
    pending_ops = {pending_ops, op};
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return DIM_W'($urandom_range(1, 12));
    if (r < 17) return DIM_W'($urandom_range(13, 256));
    if (r == 17) return DIM_W'(256);
    if (r == 18) return '0;
    return DIM_W'($urandom_range(257, 511));
  endfunction

  function automatic logic [BPP_W-1:0] pick_depth();
    case ($urandom_range(0, 6))
      0: return BPP_1;
      1: return BPP_4;
      2: return BPP_8;
      3: return BPP_24;
      4: return BPP_32;
      default: return BPP_W'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_length(cfg_t c);
    int unsigned w, h, colour, mask, total;
    w = c.width;
    h = c.height;
    case (c.depth)
      BPP_32:  colour = w * 4 * h;
      BPP_24:  colour = ((w * 3 + 3) / 4) * 4 * h;
      default: colour = (32'd4 << c.depth) + ((w * c.depth + 31) / 32) * 4 * h;
    endcase
    mask = ((w + 31) / 32) * 4 * h;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: total = colour + mask;
      4, 5:       total = (mask != 0) ? colour + $urandom_range(0, mask - 1) : colour;
      6:          total = $urandom_range(0, colour);
      7:          total = STORE_BYTES;
      8:          total = 524287;
      default:    total = $urandom_range(0, 524287);
    endcase
    return LEN_W'(total > 524287 ? 524287 : total);
  endfunction

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    cfg_t        c;
    int unsigned cx;
    int unsigned cy;
    int unsigned stop;
    bit          dims_ok;
    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.kind = KIND_WRITE;
    req_bus.byte_address = '0;
    req_bus.byte_value = '0;
    req_bus.column = '0;
    req_bus.row_from_top = '0;
    res_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_WIDTH;
    cfg_bus.data = '0;
    mismatches = 0;
    hold_request = 1'b0;
    calm = 1'b0;
    plan_cfg = '{width: 9'd1, height: 9'd1, depth: BPP_32, length: '0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset geometry: 1x1 BGRA, empty payload
    queue_read(0, 0);
    queue_read(0, 1);
    queue_read(255, 255);
    set_geometry('{width: 2, height: 2, depth: BPP_32, length: 16});
    queue_write(0, 8'h00);
    queue_write(15, 8'hFF);
    queue_read(0, 0);
    queue_read(1, 1);
    set_geometry('{width: 4, height: 4, depth: 6'd0, length: 100});
    queue_read(0, 0);
    set_geometry('{width: 4, height: 4, depth: 6'd63, length: 100});
    queue_read(200, 200);
    set_geometry('{width: 4, height: 4, depth: BPP_8, length: 1024});
    queue_read(9, 9);
    set_geometry('{width: 2, height: 2, depth: BPP_4, length: 64});
    queue_read(0, 0);
    set_geometry('{width: 0, height: 4, depth: BPP_1, length: 64});
    queue_read(0, 0);
    set_geometry('{width: 511, height: 3, depth: BPP_1, length: 64});
    queue_read(0, 0);
    set_geometry('{width: 3, height: 257, depth: BPP_24, length: 64});
    queue_read(0, 0);
    // colour rows present, mask rows cut off
    set_geometry('{width: 3, height: 2, depth: BPP_24, length: 24});
    queue_read(2, 0);
    queue_read(0, 1);
    // top rows short
    set_geometry('{width: 5, height: 3, depth: BPP_4, length: 70});
    queue_read(4, 0);
    queue_read(4, 2);
    set_geometry('{width: 256, height: 256, depth: BPP_1, length: LEN_W'(STORE_BYTES)});
    queue_read(255, 0);
    queue_read(0, 255);
    set_geometry('{width: 256, height: 1, depth: BPP_8, length: 524287});
    queue_read(255, 0);
    queue_read(128, 0);

    for (int p = 0; p < 25; p++) begin
      if (p == 0) begin
        c = '{width: 256, height: 256, depth: BPP_32, length: LEN_W'(STORE_BYTES)};
      end else if (p == 1) begin
        c = '{width: 1, height: 1, depth: BPP_8, length: 1028};
      end else begin
        c.width = pick_dim();
        c.height = pick_dim();
        c.depth = pick_depth();
        c.length = pick_length(c);
      end
      set_geometry(c);
      calm = ($urandom_range(0, 3) == 0);
      dims_ok = c.width != 0 && c.width <= MAX_DIM && c.height != 0 && c.height <= MAX_DIM;
      stop = (c.length < STORE_BYTES) ? c.length : STORE_BYTES;
      for (int n = 0; n < 16; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          if (stop != 0 && $urandom_range(0, 1) == 0) begin
            queue_write(ADDR_W'($urandom_range(0, stop - 1)), BYTE_W'($urandom_range(0, 255)));
          end else begin
            queue_write(ADDR_W'($urandom_range(0, 262143)), BYTE_W'($urandom_range(0, 255)));
          end
        end else begin
          if (dims_ok && $urandom_range(0, 7) != 0) begin
            cx = $urandom_range(0, c.width - 1);
            cy = $urandom_range(0, c.height - 1);
          end else begin
            cx = $urandom_range(0, 255);
            cy = $urandom_range(0, 255);
          end
          queue_read(COORD_W'(cx), COORD_W'(cy));
        end
      end
      if (p == 4) hold_request = 1'b1;
    end
    settle();

    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dipd_pkg.sv
hw/rtl/dipd_if.sv
hw/rtl/dipd_ram.sv
hw/rtl/dipd_geom.sv
hw/rtl/dib_icon_pixel_decoder_unit.sv
hw/rtl/dipd_checker.sv
verif/dib_icon_pixel_decoder_unit_test.sv
